>>> design/mtse_pkg.sv
package mtse_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_CELLS     = 8;
  localparam int NUM_ORDERS    = 7;
  localparam int NUM_MODES     = 14;
  localparam int MIN_ORDER     = 2;
  localparam int Q_FRAC        = 32;
  localparam int HALF_SH       = 16;

  localparam int DIST_W      = 17;
  localparam int MODE_W      = 4;
  localparam int U_W         = 33;
  localparam int ACC_W       = 44;
  localparam int PH_W        = ACC_W + HALF_SH + 2;
  localparam int PL_W        = ACC_W + HALF_SH + 1;
  localparam int PR_W        = ACC_W + DIST_W + 2;
  localparam int VAL_W       = 25;
  localparam int SLP_W       = 28;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 56;

  localparam logic [DIST_W-1:0] DIST_ONE = DIST_W'(1) << HALF_SH;
  localparam logic [U_W-1:0]    U_ONE    = U_W'(1) << Q_FRAC;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [SLP_W-1:0] SLP_MAX = {1'b0, {(SLP_W-1){1'b1}}};
  localparam logic signed [SLP_W-1:0] SLP_MIN = {1'b1, {(SLP_W-1){1'b0}}};

  localparam int ES_NUM   [NUM_CELLS+1] = '{1, -1, 3, -5, 35, -63, 231, -429, 6435};
  localparam int ES_LOG   [NUM_CELLS+1] = '{0, 1, 3, 4, 7, 8, 10, 11, 15};
  localparam int DISP_NUM [NUM_CELLS+1] = '{1, -3, 6, -10, 15, -21, 28, -36, 45};

  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [DIST_W-1:0] dist_q;
    logic [U_W-1:0]    u;
    acc_t              acc_g;
    acc_t              acc_s;
  } item_t;

  function automatic logic [MODE_W-1:0] order_of(input logic [MODE_W-1:0] mode);
    logic [MODE_W-1:0] n;
    if (mode < MODE_W'(NUM_ORDERS)) begin
      n = mode + MODE_W'(MIN_ORDER);
    end else begin
      n = mode - MODE_W'(NUM_ORDERS - MIN_ORDER);
    end
    return n;
  endfunction

  // c_k in Q.32, zero above the order of the mode
  function automatic acc_t coef_g(input logic [MODE_W-1:0] mode, input int k);
    acc_t c;
    if (k > int'(order_of(mode))) begin
      c = '0;
    end else if (mode >= MODE_W'(NUM_ORDERS)) begin
      c = ACC_W'(DISP_NUM[k]) <<< Q_FRAC;
    end else begin
      c = ACC_W'(ES_NUM[k]) <<< (Q_FRAC - ES_LOG[k]);
    end
    return c;
  endfunction

  // (k+1) c_(k+1) in Q.32
  function automatic acc_t coef_s(input logic [MODE_W-1:0] mode, input int k);
    acc_t c;
    c = coef_g(mode, k + 1) * acc_t'(k + 1);
    return c;
  endfunction

endpackage

>>> design/mtse_prep.sv
module mtse_prep import mtse_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [MODE_W-1:0] split_mode,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DIST_W-1:0] in_dist,
  output logic              out_valid,
  input  logic              out_ready,
  output item_t             out_item
);

  logic              v1_r, v2_r;
  logic              en1, en2;
  logic [DIST_W-1:0] dist1_r, dist1_nxt;
  logic [MODE_W-1:0] mode1_r;
  logic [2*DIST_W-1:0] sq;
  item_t             item2_r, item2_nxt;

  assign en2      = !v2_r || out_ready;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  assign dist1_nxt = (in_dist > DIST_ONE) ? DIST_ONE : in_dist;
  assign sq        = dist1_r * dist1_r;

  always_comb begin
    item2_nxt.mode   = mode1_r;
    item2_nxt.dist_q = dist1_r;
    item2_nxt.u      = U_ONE - sq[U_W-1:0];
    item2_nxt.acc_g  = coef_g(mode1_r, NUM_CELLS);
    item2_nxt.acc_s  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      dist1_r <= dist1_nxt;
      mode1_r <= split_mode;
    end
    if (en2) item2_r <= item2_nxt;
  end

  assign out_valid = v2_r;
  assign out_item  = item2_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_dist > DIST_ONE)) |=> (dist1_r == DIST_ONE))
    else $error("distance not clamped");

  assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (item2_r.u <= U_ONE))
    else $error("u out of range");

endmodule

>>> design/mtse_cell.sv
module mtse_cell import mtse_pkg::*; #(
  parameter int K = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output item_t out_item
);

  logic                   va_r, vb_r;
  logic                   en_a, en_b;
  item_t                  a_r, b_r, b_nxt;
  logic signed [HALF_SH+1:0] u_hi;
  logic signed [HALF_SH:0]   u_lo;
  logic signed [PH_W-1:0] pg_hi_r, ps_hi_r;
  logic signed [PL_W-1:0] pg_lo_r, ps_lo_r;
  logic signed [PH_W-1:0] sum_g, sum_s, cg_ext, cs_ext, dg, ds;

  assign en_b     = !vb_r || out_ready;
  assign en_a     = !va_r || en_b;
  assign in_ready = en_a;

  assign u_hi = $signed({1'b0, in_item.u[U_W-1:HALF_SH]});
  assign u_lo = $signed({1'b0, in_item.u[HALF_SH-1:0]});

  assign sum_g  = pg_hi_r + (PH_W'(pg_lo_r) >>> HALF_SH);
  assign sum_s  = ps_hi_r + (PH_W'(ps_lo_r) >>> HALF_SH);
  assign cg_ext = PH_W'(coef_g(a_r.mode, K));
  assign cs_ext = PH_W'(coef_s(a_r.mode, K));
  assign dg     = cg_ext - (sum_g >>> HALF_SH);
  assign ds     = cs_ext - (sum_s >>> HALF_SH);

  always_comb begin
    b_nxt       = a_r;
    b_nxt.acc_g = dg[ACC_W-1:0];
    b_nxt.acc_s = ds[ACC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (en_a) va_r <= in_valid;
      if (en_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_r     <= in_item;
      pg_hi_r <= $signed(in_item.acc_g) * u_hi;
      pg_lo_r <= $signed(in_item.acc_g) * u_lo;
      ps_hi_r <= $signed(in_item.acc_s) * u_hi;
      ps_lo_r <= $signed(in_item.acc_s) * u_lo;
    end
    if (en_b) b_r <= b_nxt;
  end

  assign out_valid = vb_r;
  assign out_item  = b_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (va_r && !en_b) |=> (va_r && $stable(pg_hi_r) && $stable(ps_lo_r)))
    else $error("stalled products lost");

endmodule

>>> design/mtse_post.sv
module mtse_post import mtse_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  item_t                   in_item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] out_value,
  output logic signed [SLP_W-1:0] out_slope,
  output logic                    out_bad
);

  localparam int SH_G = Q_FRAC - FRAC_BITS;
  localparam int SH_S = Q_FRAC + HALF_SH - FRAC_BITS;
  localparam logic signed [ACC_W:0]  G_RND = (ACC_W+1)'(1) <<< (SH_G - 1);
  localparam logic signed [PR_W-1:0] S_RND = PR_W'(1) <<< (SH_S - 1);

  logic                    v1_r, v2_r, en1, en2;
  logic                    bad, bad1_r, bad2_r;
  logic signed [VAL_W-1:0] val1_r, val1_nxt, val2_r;
  logic signed [SLP_W-1:0] slp2_r, slp2_nxt;
  logic signed [PR_W-1:0]  prod1_r, s_sum, s_q;
  logic signed [ACC_W:0]   g_sum, g_q;
  logic signed [DIST_W+1:0] two_r;

  assign en2      = !v2_r || out_ready;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  assign bad   = in_item.mode >= MODE_W'(NUM_MODES);
  assign two_r = $signed({1'b0, in_item.dist_q, 1'b0});
  assign g_sum = (ACC_W+1)'($signed(in_item.acc_g)) + G_RND;
  assign g_q   = g_sum >>> SH_G;

  always_comb begin
    if (bad) begin
      val1_nxt = '0;
    end else if (g_q > (ACC_W+1)'(VAL_MAX)) begin
      val1_nxt = VAL_MAX;
    end else if (g_q < (ACC_W+1)'(VAL_MIN)) begin
      val1_nxt = VAL_MIN;
    end else begin
      val1_nxt = g_q[VAL_W-1:0];
    end
  end

  assign s_sum = prod1_r + S_RND;
  assign s_q   = s_sum >>> SH_S;

  always_comb begin
    if (bad1_r) begin
      slp2_nxt = '0;
    end else if (s_q > PR_W'(SLP_MAX)) begin
      slp2_nxt = SLP_MAX;
    end else if (s_q < PR_W'(SLP_MIN)) begin
      slp2_nxt = SLP_MIN;
    end else begin
      slp2_nxt = s_q[SLP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      bad1_r  <= bad;
      val1_r  <= val1_nxt;
      prod1_r <= $signed(in_item.acc_s) * two_r;
    end
    if (en2) begin
      bad2_r <= bad1_r;
      val2_r <= val1_r;
      slp2_r <= slp2_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_value = val2_r;
  assign out_slope = slp2_r;
  assign out_bad   = bad2_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && bad2_r) |-> ((val2_r == '0) && (slp2_r == '0)))
    else $error("undefined mode gave non-zero result");

  assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !en2) |=> (v1_r && $stable(prod1_r) && $stable(val1_r)))
    else $error("stalled result stage changed");

endmodule

>>> design/msm_taylor_splitting_eval_unit.sv
// Pipeline: each input transfer passes through 2 setup stages, 8 Horner cells of
//   2 stages and 2 output stages before its result is presented.
// Throughput: one item per cycle; every stage holds its own item and stalls only when full.
// Reset (rst_n low, synchronous): split_mode returns to 0, all stage valid bits clear.
module msm_taylor_splitting_eval_unit import mtse_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // scaled_distance [16:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // smooth_value [24:0], smooth_slope [52:25]
  output logic                   out_tuser,  // bad_mode
  input  logic                   cfg_wr_en,
  input  logic [MODE_W-1:0]      cfg_wr_data
);

  logic [MODE_W-1:0]       split_mode_r;
  logic                    chain_valid [NUM_CELLS+1];
  logic                    chain_ready [NUM_CELLS+1];
  item_t                   chain_item  [NUM_CELLS+1];
  logic signed [VAL_W-1:0] smooth_value;
  logic signed [SLP_W-1:0] smooth_slope;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      split_mode_r <= '0;
    end else if (cfg_wr_en) begin
      split_mode_r <= cfg_wr_data;
    end
  end

  mtse_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .split_mode (split_mode_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_dist    (in_tdata[DIST_W-1:0]),
    .out_valid  (chain_valid[0]),
    .out_ready  (chain_ready[0]),
    .out_item   (chain_item[0])
  );

  for (genvar j = 0; j < NUM_CELLS; j++) begin : g_cell
    mtse_cell #(
      .K (NUM_CELLS - 1 - j)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_valid[j]),
      .in_ready  (chain_ready[j]),
      .in_item   (chain_item[j]),
      .out_valid (chain_valid[j+1]),
      .out_ready (chain_ready[j+1]),
      .out_item  (chain_item[j+1])
    );
  end

  mtse_post #(
    .FRAC_BITS (FRAC_BITS)
  ) u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chain_valid[NUM_CELLS]),
    .in_ready  (chain_ready[NUM_CELLS]),
    .in_item   (chain_item[NUM_CELLS]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_value (smooth_value),
    .out_slope (smooth_slope),
    .out_bad   (out_tuser)
  );

  assign out_tdata = {(OUT_TDATA_W-SLP_W-VAL_W)'(0), smooth_slope, smooth_value};

endmodule
